FILE: hdl/imusc_pkg.sv
// ----------------------------------------------------------------------------
// imusc_pkg
// Shared constants, codes and helper functions for the inertial sample
// scaler, calibrator and tilt core.
// ----------------------------------------------------------------------------
package imusc_pkg;

    // Beat widths
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 160;

    // Tilt angle iterations (capped at the length of the arctangent table)
    localparam int ANGLE_ITERATIONS = 16;
    localparam int CORDIC_ITER      = (ANGLE_ITERATIONS < 24) ? ANGLE_ITERATIONS : 24;

    // Fixed-point constants
    localparam logic signed [20:0] ACC_G_Q16  = 21'sd642908;   // 9.81 in Q16
    localparam logic signed [20:0] TEMP_K     = 21'sd49345;    // 1/340 scaled
    localparam logic signed [39:0] TEMP_OFS   = 40'sd612871700;
    localparam logic signed [39:0] GRAVITY_Q8 = 40'sd2511;     // 9.81 in Q8
    localparam logic signed [39:0] ANGLE_MAX  = 40'sd23040;    // 90 deg in Q8

    // Register indexes
    localparam logic [1:0] REG_GYRO_RANGE  = 2'd0;
    localparam logic [1:0] REG_ACCEL_RANGE = 2'd1;
    localparam logic [1:0] REG_CAL_SAMPLES = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_MEASURED   = 2'd0;
    localparam logic [1:0] ST_CAL_SAMPLE = 2'd1;
    localparam logic [1:0] ST_CAL_DONE   = 2'd2;

    // Gyro scale factor, 64/sensitivity in Q16
    function automatic logic signed [20:0] gyro_k(input logic [1:0] rng);
        logic signed [20:0] k;
        case (rng)
            2'd0:    k = 21'sd32018;
            2'd1:    k = 21'sd64035;
            2'd2:    k = 21'sd127875;
            default: k = 21'sd255750;
        endcase
        return k;
    endfunction

    // Arctangent of 2^-i in Q16 degrees
    function automatic logic signed [23:0] atan_q16(input logic [4:0] i);
        logic signed [23:0] a;
        case (i)
            5'd0:  a = 24'sd2949120;
            5'd1:  a = 24'sd1740967;
            5'd2:  a = 24'sd919879;
            5'd3:  a = 24'sd466945;
            5'd4:  a = 24'sd234379;
            5'd5:  a = 24'sd117304;
            5'd6:  a = 24'sd58666;
            5'd7:  a = 24'sd29335;
            5'd8:  a = 24'sd14668;
            5'd9:  a = 24'sd7334;
            5'd10: a = 24'sd3667;
            5'd11: a = 24'sd1833;
            5'd12: a = 24'sd917;
            5'd13: a = 24'sd458;
            5'd14: a = 24'sd229;
            5'd15: a = 24'sd115;
            5'd16: a = 24'sd57;
            5'd17: a = 24'sd29;
            5'd18: a = 24'sd14;
            5'd19: a = 24'sd7;
            5'd20: a = 24'sd4;
            5'd21: a = 24'sd2;
            5'd22: a = 24'sd1;
            default: a = 24'sd0;
        endcase
        return a;
    endfunction

    // Saturate to 16, 18 and 19 bits
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767)       r = 16'sh7fff;
        else if (v < -40'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [17:0] sat18(input logic signed [39:0] v);
        logic signed [17:0] r;
        if (v > 40'sd131071)       r = 18'sh1ffff;
        else if (v < -40'sd131072) r = 18'sh20000;
        else                       r = v[17:0];
        return r;
    endfunction

    function automatic logic signed [18:0] sat19(input logic signed [39:0] v);
        logic signed [18:0] r;
        if (v > 40'sd262143)       r = 19'sh3ffff;
        else if (v < -40'sd262144) r = 19'sh40000;
        else                       r = v[18:0];
        return r;
    endfunction

endpackage

FILE: hdl/imu_sample_scale_calibrate_tilt_core.sv
// Items are handled one at a time: a new beat is taken only in idle, after the
// previous result has been loaded into the output register; an unread result
// stalls the next one. One multiplier forms the eleven scale and square
// products, then square root, CORDIC and division step once a cycle; a
// calibration item that completes a run adds six divisions.
// Reset (aresetn, synchronous): ranges 0, sample count 100, offsets, sums, count 0.
// ----------------------------------------------------------------------------
// imu_sample_scale_calibrate_tilt_core
// Scales a raw six-axis sample and temperature, removes calibration offsets,
// estimates pitch and roll, and accumulates calibration averages.
// ----------------------------------------------------------------------------
module imu_sample_scale_calibrate_tilt_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_addr,
    input  logic [15:0]                       cfg_wr_data,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel x, accel y, accel z, gyro x, gyro y, gyro z, temperature
    // (raw, 16 bits each)
    input  logic [imusc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tuser,   // mode
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // accel_x_out, accel_y_out, accel_z_out (18), gyro_x_out, gyro_y_out,
    // gyro_z_out (19), temperature, pitch, roll (16), one zero pad bit
    output logic [imusc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [1:0]                        m_tuser    // status
);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ACC   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_CINIT = 4'd4;
    localparam logic [3:0] S_CORD  = 4'd5;
    localparam logic [3:0] S_CEND  = 4'd6;
    localparam logic [3:0] S_CAL   = 4'd7;
    localparam logic [3:0] S_DINIT = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DEND  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // Sequence positions
    localparam logic [3:0] IDX_LAST_MUL = 4'd10;
    localparam logic [3:0] IDX_LAST_DIV = 4'd5;
    localparam logic [5:0] SQRT_LAST    = 6'd17;
    localparam logic [5:0] CORD_LAST    = 6'(imusc_pkg::CORDIC_ITER - 1);
    localparam logic [5:0] DIV_LAST     = 6'd36;

    logic [3:0]  state_reg;
    logic [3:0]  idx_reg;
    logic [5:0]  step_reg;
    logic        ang_reg;
    logic        mode_reg;
    logic [1:0]  status_reg;

    logic [1:0]  gyro_range_reg;
    logic [1:0]  accel_range_reg;
    logic [15:0] cal_samples_reg;

    logic signed [15:0] raw_reg [0:6];
    logic signed [39:0] prod_reg;
    logic signed [18:0] sc_reg  [0:5];
    logic signed [18:0] cor_reg [0:5];
    logic signed [15:0] temp_reg;
    logic [35:0] sqa_reg;
    logic [35:0] sqb_reg;

    logic [35:0] rad_reg;
    logic [35:0] root_reg;
    logic [35:0] bit_reg;

    logic signed [29:0] x_reg;
    logic signed [29:0] y_reg;
    logic signed [25:0] z_reg;
    logic               zero_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] roll_reg;

    logic signed [17:0] acc_off_reg [0:2];
    logic signed [18:0] gyr_off_reg [0:2];
    logic signed [35:0] sum_reg     [0:5];
    logic [15:0]        cnt_reg;

    logic [36:0] num_reg;
    logic [16:0] rem_reg;
    logic        neg_reg;

    logic                            m_tvalid_reg;
    logic [imusc_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]                      m_tuser_reg;

    // Shared multiplier operand select
    logic signed [18:0] mul_a;
    logic signed [20:0] mul_b;
    always_comb begin
        case (idx_reg)
            4'd0:    begin mul_a = 19'(raw_reg[0]); mul_b = imusc_pkg::ACC_G_Q16; end
            4'd1:    begin mul_a = 19'(raw_reg[1]); mul_b = imusc_pkg::ACC_G_Q16; end
            4'd2:    begin mul_a = 19'(raw_reg[2]); mul_b = imusc_pkg::ACC_G_Q16; end
            4'd3:    begin mul_a = 19'(raw_reg[3]); mul_b = imusc_pkg::gyro_k(gyro_range_reg); end
            4'd4:    begin mul_a = 19'(raw_reg[4]); mul_b = imusc_pkg::gyro_k(gyro_range_reg); end
            4'd5:    begin mul_a = 19'(raw_reg[5]); mul_b = imusc_pkg::gyro_k(gyro_range_reg); end
            4'd6:    begin mul_a = 19'(raw_reg[6]); mul_b = imusc_pkg::TEMP_K; end
            4'd7:    begin mul_a = cor_reg[0]; mul_b = 21'(cor_reg[0]); end
            4'd8:    begin mul_a = cor_reg[2]; mul_b = 21'(cor_reg[2]); end
            4'd9:    begin mul_a = cor_reg[1]; mul_b = 21'(cor_reg[1]); end
            default: begin mul_a = cor_reg[2]; mul_b = 21'(cor_reg[2]); end
        endcase
    end

    // Full-width signed product
    logic signed [39:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Offset for the channel being corrected
    logic signed [18:0] off_sel;
    always_comb begin
        case (idx_reg)
            4'd0:    off_sel = 19'(acc_off_reg[0]);
            4'd1:    off_sel = 19'(acc_off_reg[1]);
            4'd2:    off_sel = 19'(acc_off_reg[2]);
            4'd3:    off_sel = gyr_off_reg[0];
            4'd4:    off_sel = gyr_off_reg[1];
            default: off_sel = gyr_off_reg[2];
        endcase
    end

    // Round the product into scaled units
    logic signed [39:0] acc_shift;
    logic signed [18:0] acc_sc;
    logic signed [18:0] gyr_sc;
    logic signed [39:0] temp_full;
    logic signed [18:0] sc_sel;
    logic signed [39:0] cor_diff;
    always_comb begin
        acc_shift = prod_reg <<< accel_range_reg;
        acc_sc    = 19'((acc_shift + 40'sd2097152) >>> 22);
        gyr_sc    = 19'((prod_reg + 40'sd32768) >>> 16);
        temp_full = (prod_reg + imusc_pkg::TEMP_OFS + 40'sd32768) >>> 16;
        sc_sel    = (idx_reg < 4'd3) ? acc_sc : gyr_sc;
        cor_diff  = 40'(sc_sel) - 40'(off_sel);
    end

    // Square root trial subtract
    logic [36:0] sqrt_trial;
    logic        sqrt_take;
    assign sqrt_trial = 37'(root_reg) + 37'(bit_reg);
    assign sqrt_take  = 37'(rad_reg) >= sqrt_trial;

    // CORDIC rotation step
    logic signed [29:0] x_sh;
    logic signed [29:0] y_sh;
    logic signed [25:0] atan_step;
    assign x_sh      = x_reg >>> step_reg[4:0];
    assign y_sh      = y_reg >>> step_reg[4:0];
    assign atan_step = 26'(imusc_pkg::atan_q16(step_reg[4:0]));

    // Angle rounding and clamp
    logic signed [39:0] z_round;
    logic signed [15:0] ang_final;
    always_comb begin
        z_round = (40'(z_reg) + 40'sd128) >>> 8;
        if (zero_reg)                           ang_final = 16'sd0;
        else if (z_round > imusc_pkg::ANGLE_MAX)  ang_final = 16'(imusc_pkg::ANGLE_MAX);
        else if (z_round < -imusc_pkg::ANGLE_MAX) ang_final = 16'(-imusc_pkg::ANGLE_MAX);
        else                                    ang_final = z_round[15:0];
    end

    // Tilt operands for the angle in progress
    logic signed [18:0] yin;
    assign yin = ang_reg ? -cor_reg[0] : cor_reg[1];

    // Calibration count check
    logic [16:0] cnt_inc;
    logic [15:0] target;
    assign cnt_inc = 17'(cnt_reg) + 17'd1;
    assign target  = (cal_samples_reg == 16'd0) ? 16'd1 : cal_samples_reg;

    // Divider step and result
    logic signed [35:0] sum_sel;
    logic [36:0]        sum_mag;
    logic [17:0]        rem_shift;
    logic               div_take;
    logic signed [39:0] avg_val;
    logic signed [39:0] acc_avg;
    always_comb begin
        sum_sel   = sum_reg[idx_reg[2:0]];
        sum_mag   = sum_sel[35] ? 37'(-(37'(sum_sel))) : 37'(sum_sel);
        rem_shift = {rem_reg, num_reg[36]};
        div_take  = rem_shift >= {2'b00, cnt_reg};
        avg_val   = neg_reg ? -(40'({3'b000, num_reg})) : 40'({3'b000, num_reg});
        acc_avg   = (idx_reg == 4'd2) ? avg_val - imusc_pkg::GRAVITY_Q8 : avg_val;
    end

    // Output register may be loaded when empty or being drained
    logic out_load;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gyro_range_reg  <= 2'd0;
            accel_range_reg <= 2'd0;
            cal_samples_reg <= 16'd100;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                imusc_pkg::REG_GYRO_RANGE:  gyro_range_reg  <= cfg_wr_data[1:0];
                imusc_pkg::REG_ACCEL_RANGE: accel_range_reg <= cfg_wr_data[1:0];
                imusc_pkg::REG_CAL_SAMPLES: cal_samples_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Sequencer and shared datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            idx_reg    <= 4'd0;
            step_reg   <= 6'd0;
            ang_reg    <= 1'b0;
            cnt_reg    <= 16'd0;
            for (int i = 0; i < 3; i++) begin
                acc_off_reg[i] <= '0;
                gyr_off_reg[i] <= '0;
            end
            for (int i = 0; i < 6; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    // Take the input beat
                    if (s_tvalid) begin
                        for (int i = 0; i < 7; i++) begin
                            raw_reg[i] <= s_tdata[16*i +: 16];
                        end
                        mode_reg   <= s_tuser;
                        status_reg <= imusc_pkg::ST_MEASURED;
                        idx_reg    <= 4'd0;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    // Fold the product into its destination
                    case (idx_reg)
                        4'd0, 4'd1, 4'd2: begin
                            sc_reg[idx_reg[2:0]]  <= acc_sc;
                            cor_reg[idx_reg[2:0]] <= 19'(imusc_pkg::sat18(cor_diff));
                        end
                        4'd3, 4'd4, 4'd5: begin
                            sc_reg[idx_reg[2:0]]  <= gyr_sc;
                            cor_reg[idx_reg[2:0]] <= imusc_pkg::sat19(cor_diff);
                        end
                        4'd6: temp_reg <= imusc_pkg::sat16(temp_full);
                        4'd7: sqa_reg  <= prod_reg[35:0];
                        4'd8: sqa_reg  <= sqa_reg + prod_reg[35:0];
                        4'd9: sqb_reg  <= prod_reg[35:0];
                        default: sqb_reg <= sqb_reg + prod_reg[35:0];
                    endcase
                    if (idx_reg == IDX_LAST_MUL) begin
                        rad_reg   <= sqa_reg;
                        root_reg  <= '0;
                        bit_reg   <= 36'h4_0000_0000;
                        step_reg  <= 6'd0;
                        ang_reg   <= 1'b0;
                        state_reg <= S_SQRT;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_SQRT: begin
                    // One root bit per cycle
                    if (sqrt_take) begin
                        rad_reg  <= 36'(37'(rad_reg) - sqrt_trial);
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg  <= bit_reg >> 2;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == SQRT_LAST) begin
                        state_reg <= S_CINIT;
                    end
                end
                S_CINIT: begin
                    x_reg     <= 30'(root_reg) <<< 8;
                    y_reg     <= 30'(yin) <<< 8;
                    z_reg     <= '0;
                    zero_reg  <= (root_reg == '0) && (yin == '0);
                    step_reg  <= 6'd0;
                    state_reg <= S_CORD;
                end
                S_CORD: begin
                    // Rotate toward the x axis
                    if (!y_reg[29]) begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_step;
                    end else begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_step;
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == CORD_LAST) begin
                        state_reg <= S_CEND;
                    end
                end
                S_CEND: begin
                    if (!ang_reg) begin
                        pitch_reg <= ang_final;
                        rad_reg   <= sqb_reg;
                        root_reg  <= '0;
                        bit_reg   <= 36'h4_0000_0000;
                        step_reg  <= 6'd0;
                        ang_reg   <= 1'b1;
                        state_reg <= S_SQRT;
                    end else begin
                        roll_reg  <= ang_final;
                        state_reg <= mode_reg ? S_CAL : S_DONE;
                    end
                end
                S_CAL: begin
                    // Accumulate scaled values and advance the count
                    for (int i = 0; i < 6; i++) begin
                        sum_reg[i] <= sum_reg[i] + 36'(sc_reg[i]);
                    end
                    cnt_reg    <= cnt_inc[15:0];
                    status_reg <= imusc_pkg::ST_CAL_SAMPLE;
                    idx_reg    <= 4'd0;
                    state_reg  <= (cnt_inc >= 17'(target)) ? S_DINIT : S_DONE;
                end
                S_DINIT: begin
                    num_reg   <= sum_mag + 37'(cnt_reg >> 1);
                    neg_reg   <= sum_sel[35];
                    rem_reg   <= '0;
                    step_reg  <= 6'd0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle
                    if (div_take) begin
                        rem_reg <= 17'(rem_shift - {2'b00, cnt_reg});
                    end else begin
                        rem_reg <= rem_shift[16:0];
                    end
                    num_reg  <= {num_reg[35:0], div_take};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == DIV_LAST) begin
                        state_reg <= S_DEND;
                    end
                end
                S_DEND: begin
                    case (idx_reg)
                        4'd0, 4'd1, 4'd2: acc_off_reg[idx_reg[1:0]] <= imusc_pkg::sat18(acc_avg);
                        4'd3:    gyr_off_reg[0] <= imusc_pkg::sat19(avg_val);
                        4'd4:    gyr_off_reg[1] <= imusc_pkg::sat19(avg_val);
                        default: gyr_off_reg[2] <= imusc_pkg::sat19(avg_val);
                    endcase
                    if (idx_reg == IDX_LAST_DIV) begin
                        for (int i = 0; i < 6; i++) begin
                            sum_reg[i] <= '0;
                        end
                        cnt_reg    <= 16'd0;
                        status_reg <= imusc_pkg::ST_CAL_DONE;
                        state_reg  <= S_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= S_DINIT;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output register: hold the result until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, roll_reg, pitch_reg, temp_reg,
                            cor_reg[5], cor_reg[4], cor_reg[3],
                            cor_reg[2][17:0], cor_reg[1][17:0], cor_reg[0][17:0]};
            m_tuser_reg <= status_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Assertions
    a_busy_after_accept : assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    a_status_code : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined status code on result beat");

    a_done_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DEND && idx_reg == IDX_LAST_DIV |=> cnt_reg == 16'd0)
        else $error("calibration count not cleared at run end");

    a_cal_status : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !mode_reg |=> m_tuser == imusc_pkg::ST_MEASURED)
        else $error("measure item reported a calibration status");

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives raw inertial samples into the scale/calibrate/tilt core with random
// gaps on both streams, predicts every result beat from its own model of the
// scaling, offsets, calibration averaging and CORDIC tilt, and compares each
// result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int LONG_HOLD = 3000;
    localparam int DRAIN_CYCLES = 400;
    localparam int FOFS [9] = '{0, 18, 36, 54, 73, 92, 111, 127, 143};
    localparam int FWID [9] = '{18, 18, 18, 19, 19, 19, 16, 16, 16};
    localparam longint ATAN_TBL [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0};
    localparam longint GYRO_K_TBL [4] = '{32018, 64035, 127875, 255750};

    typedef struct {
        bit                 mode;
        logic signed [15:0] raw [7];   // ax, ay, az, gx, gy, gz, temp
    } sample_t;

    typedef struct {
        logic [imusc_pkg::M_TDATA_W-1:0] data;
        logic [1:0]                      status;
    } imu_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [1:0]                      cfg_addr;
    logic [15:0]                     cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [imusc_pkg::S_TDATA_W-1:0] s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [imusc_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0]                      m_tuser;

    imu_sample_scale_calibrate_tilt_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Model state
    longint          acc_ofs [3];
    longint          gyr_ofs [3];
    longint          cal_sum [6];
    longint unsigned cal_cnt;
    logic [1:0]      cfg_grng, cfg_arng;
    logic [15:0]     cfg_ncal;

    sample_t     pending_samples [$];
    imu_result_t expected_results [$];
    int          errors;
    bit          tx_nogap, rx_nogap, long_hold_req;

    // floor(v / 2^s + 1/2)
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_bits(longint v, int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC atan2(y, x), x >= 0, Q8 degrees
    function automatic longint tilt_angle(longint y, longint x);
        longint z, xs, ys;
        if (x == 0 && y == 0) return 0;
        z = 0;
        x = x * 256;
        y = y * 256;
        for (int i = 0; i < imusc_pkg::CORDIC_ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
            end
        end
        z = round_shift(z, 8);
        return clamp_bits(z, 40) > 23040 ? 23040 : (z < -23040 ? -23040 : z);
    endfunction

    // Average rounded half away from zero
    function automatic longint mean_away(longint sum, longint unsigned n);
        longint unsigned m;
        longint q;
        m = sum < 0 ? longint'(-sum) : sum;
        q = longint'((m + n / 2) / n);
        return sum < 0 ? -q : q;
    endfunction

    // Compute the result of one accepted sample and advance calibration state
    function automatic void predict_sample(sample_t it);
        longint sc [6];
        longint cor [6];
        longint r [9];
        longint unsigned target;
        imu_result_t e;
        logic [1:0] st;
        for (int i = 0; i < 3; i++) begin
            sc[i] = round_shift(longint'(it.raw[i]) * 642908 * (64'sd1 <<< cfg_arng), 22);
            sc[3+i] = round_shift(longint'(it.raw[3+i]) * GYRO_K_TBL[cfg_grng], 16);
            cor[i] = clamp_bits(sc[i] - acc_ofs[i], 18);
            cor[3+i] = clamp_bits(sc[3+i] - gyr_ofs[i], 19);
        end
        for (int i = 0; i < 6; i++) r[i] = cor[i];
        r[6] = clamp_bits(round_shift(longint'(it.raw[6]) * 49345 + 612871700, 16), 16);
        r[7] = tilt_angle(cor[1], longint'(int_sqrt(cor[0] * cor[0] + cor[2] * cor[2])));
        r[8] = tilt_angle(-cor[0], longint'(int_sqrt(cor[1] * cor[1] + cor[2] * cor[2])));
        st = imusc_pkg::ST_MEASURED;
        if (it.mode) begin
            target = (cfg_ncal == 0) ? 1 : cfg_ncal;
            for (int i = 0; i < 6; i++) cal_sum[i] += sc[i];
            cal_cnt++;
            st = imusc_pkg::ST_CAL_SAMPLE;
            if (cal_cnt >= target) begin
                for (int i = 0; i < 3; i++) begin
                    acc_ofs[i] = mean_away(cal_sum[i], cal_cnt);
                    if (i == 2) acc_ofs[i] -= 2511;
                    acc_ofs[i] = clamp_bits(acc_ofs[i], 18);
                    gyr_ofs[i] = clamp_bits(mean_away(cal_sum[3+i], cal_cnt), 19);
                end
                for (int i = 0; i < 6; i++) cal_sum[i] = 0;
                cal_cnt = 0;
                st = imusc_pkg::ST_CAL_DONE;
            end
        end
        e.data = '0;
        for (int f = 0; f < 9; f++)
            for (int b = 0; b < FWID[f]; b++) e.data[FOFS[f] + b] = r[f][b];
        e.status = st;
        expected_results.push_back(e);
    endfunction

    function automatic logic signed [15:0] draw_raw();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t make_sample(bit mode, logic signed [15:0] v);
        sample_t s;
        s.mode = mode;
        for (int k = 0; k < 7; k++) s.raw[k] = v;
        return s;
    endfunction

    function automatic sample_t rand_sample(bit mode);
        sample_t s;
        s.mode = mode;
        for (int k = 0; k < 7; k++) s.raw[k] = draw_raw();
        return s;
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Input driver: hold a beat until taken, then wait its gap
    int gap_cnt;
    sample_t it_cur;
    always @(posedge aclk) begin
        sample_t it;
        logic nv;
        logic [imusc_pkg::S_TDATA_W-1:0] dv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            gap_cnt  = 0;
        end else begin
            if (s_tvalid && s_tready) predict_sample(it_cur);
            if (!(s_tvalid && !s_tready)) begin
                nv = 1'b0;
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pending_samples.size() > 0) begin
                    it = pending_samples.pop_front();
                    it_cur = it;
                    for (int k = 0; k < 7; k++) dv[16*k +: 16] = it.raw[k];
                    s_tdata <= dv;
                    s_tuser <= it.mode;
                    nv = 1'b1;
                    gap_cnt = tx_nogap ? 0 : $urandom_range(0, 16);
                end
                s_tvalid <= nv;
            end
        end
    end

    // Result monitor: compare beats, draw stalls, take one long hold-off
    int  rx_wait;
    bit  long_held;
    always @(posedge aclk) begin
        imu_result_t e;
        logic [18:0] got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
            long_held = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat data=%h status=%0d",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    for (int f = 0; f < 9; f++) begin
                        got = '0;
                        want = '0;
                        for (int b = 0; b < FWID[f]; b++) begin
                            got[b] = m_tdata[FOFS[f] + b];
                            want[b] = e.data[FOFS[f] + b];
                        end
                        if (got !== want) begin
                            $display("%0t: field %0d expected %h actual %h",
                                     $time, f, want, got);
                            errors++;
                        end
                    end
                    if (m_tdata[imusc_pkg::M_TDATA_W-1] !== 1'b0) begin
                        $display("%0t: pad bit expected 0 actual %b",
                                 $time, m_tdata[imusc_pkg::M_TDATA_W-1]);
                        errors++;
                    end
                    if (m_tuser !== e.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, m_tuser);
                        errors++;
                    end
                end
                rx_wait = rx_nogap ? 0 : $urandom_range(0, 16);
            end
            if (long_hold_req && !long_held) begin
                rx_wait = LONG_HOLD;
                long_held = 1;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Wait until every queued beat is sent and every result has come back
    task automatic wait_idle();
        while (pending_samples.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == imusc_pkg::REG_GYRO_RANGE)       cfg_grng = val[1:0];
        else if (idx == imusc_pkg::REG_ACCEL_RANGE) cfg_arng = val[1:0];
        else if (idx == imusc_pkg::REG_CAL_SAMPLES) cfg_ncal = val;
    endtask

    // Stimulus sequencer
    initial begin
        sample_t s;
        int n;
        errors = 0;
        tx_nogap = 0;
        rx_nogap = 0;
        long_hold_req = 0;
        cfg_grng = 0;
        cfg_arng = 0;
        cfg_ncal = 100;
        cal_cnt = 0;
        for (int i = 0; i < 3; i++) begin acc_ofs[i] = 0; gyr_ofs[i] = 0; end
        for (int i = 0; i < 6; i++) cal_sum[i] = 0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= '0;
        cfg_wr_data <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Ignored index, then extremes and a zero vector at reset ranges
        write_reg(REG_UNUSED, 16'hffff);
        pending_samples.push_back(make_sample(1'b0, 16'sh0000));
        pending_samples.push_back(make_sample(1'b0, 16'sh7fff));
        pending_samples.push_back(make_sample(1'b0, 16'sh8000));
        s = make_sample(1'b0, 16'sh0000);
        s.raw[0] = 16'sh7fff; s.raw[2] = 16'sh8000; s.raw[4] = 16'sh8000;
        pending_samples.push_back(s);
        s = make_sample(1'b0, 16'sh0000);
        s.raw[1] = 16'sh8000; s.raw[0] = 16'sh0001;
        pending_samples.push_back(s);
        wait_idle();

        // Zero sample count acts as one: a single calibration item completes
        write_reg(imusc_pkg::REG_GYRO_RANGE, 16'hfffb);
        write_reg(imusc_pkg::REG_ACCEL_RANGE, 16'h0007);
        write_reg(imusc_pkg::REG_CAL_SAMPLES, 16'h0000);
        pending_samples.push_back(make_sample(1'b1, 16'sh7fff));
        pending_samples.push_back(make_sample(1'b0, 16'sh7fff));
        pending_samples.push_back(make_sample(1'b0, 16'sh8000));
        wait_idle();

        // Largest count, measure items interleaved, range change mid-run
        write_reg(imusc_pkg::REG_CAL_SAMPLES, 16'hffff);
        pending_samples.push_back(rand_sample(1'b1));
        pending_samples.push_back(rand_sample(1'b0));
        pending_samples.push_back(rand_sample(1'b1));
        wait_idle();
        write_reg(imusc_pkg::REG_ACCEL_RANGE, 16'h0001);
        write_reg(imusc_pkg::REG_GYRO_RANGE, 16'h0002);
        pending_samples.push_back(rand_sample(1'b1));
        wait_idle();
        // Count lowered below what is summed: next calibration item completes
        write_reg(imusc_pkg::REG_CAL_SAMPLES, 16'h0002);
        pending_samples.push_back(rand_sample(1'b1));
        pending_samples.push_back(rand_sample(1'b0));
        pending_samples.push_back(make_sample(1'b0, 16'sh0000));
        wait_idle();

        // Random phases
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            write_reg(imusc_pkg::REG_GYRO_RANGE,
                      ph == 0 ? 16'h0000 : (ph == 7 ? 16'h0003 : 16'($urandom)));
            write_reg(imusc_pkg::REG_ACCEL_RANGE,
                      ph == 0 ? 16'h0000 : (ph == 7 ? 16'h0003 : 16'($urandom)));
            write_reg(imusc_pkg::REG_CAL_SAMPLES,
                      ph == 1 ? 16'h0001 : 16'($urandom_range(0, 12)));
            tx_nogap = (ph % 3 == 0);
            rx_nogap = (ph % 4 == 1);
            if (ph == 2) long_hold_req = 1;
            n = 0;
            while (n < 165) begin
                pending_samples.push_back(rand_sample($urandom_range(0, 2) == 0));
                n++;
            end
        end
        wait_idle();
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
